@@ rtl/pl0vm_pkg.sv @@
package pl0vm_pkg;

    localparam int unsigned OP_W    = 5;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned PC_W    = 16;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned RIDX_W  = 4;
    localparam int unsigned TOP_W   = 8;
    localparam int unsigned BASE_W  = 7;

    localparam logic [OP_W-1:0] OP_LIT = 5'd1;
    localparam logic [OP_W-1:0] OP_RET = 5'd2;
    localparam logic [OP_W-1:0] OP_LOD = 5'd3;
    localparam logic [OP_W-1:0] OP_STO = 5'd4;
    localparam logic [OP_W-1:0] OP_CAL = 5'd5;
    localparam logic [OP_W-1:0] OP_INC = 5'd6;
    localparam logic [OP_W-1:0] OP_JMP = 5'd7;
    localparam logic [OP_W-1:0] OP_JPC = 5'd8;
    localparam logic [OP_W-1:0] OP_WRT = 5'd9;
    localparam logic [OP_W-1:0] OP_RED = 5'd10;
    localparam logic [OP_W-1:0] OP_HLT = 5'd11;
    localparam logic [OP_W-1:0] OP_NEG = 5'd12;
    localparam logic [OP_W-1:0] OP_ADD = 5'd13;
    localparam logic [OP_W-1:0] OP_SUB = 5'd14;
    localparam logic [OP_W-1:0] OP_MUL = 5'd15;
    localparam logic [OP_W-1:0] OP_DIV = 5'd16;
    localparam logic [OP_W-1:0] OP_MOD = 5'd17;
    localparam logic [OP_W-1:0] OP_EQL = 5'd18;
    localparam logic [OP_W-1:0] OP_NEQ = 5'd19;
    localparam logic [OP_W-1:0] OP_LSS = 5'd20;
    localparam logic [OP_W-1:0] OP_LEQ = 5'd21;
    localparam logic [OP_W-1:0] OP_GTR = 5'd22;
    localparam logic [OP_W-1:0] OP_GEQ = 5'd23;

    localparam logic [STAT_W-1:0] ST_RUN    = 3'd0;
    localparam logic [STAT_W-1:0] ST_HALT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVF    = 3'd2;
    localparam logic [STAT_W-1:0] ST_OOB    = 3'd3;
    localparam logic [STAT_W-1:0] ST_DIV0   = 3'd4;
    localparam logic [STAT_W-1:0] ST_BADREG = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [RIDX_W-1:0]        target_reg;
        logic [RIDX_W-1:0]        level_or_reg;
        logic signed [WORD_W-1:0] operand_m;
        logic signed [WORD_W-1:0] read_value;
    } instr_t;

    typedef struct packed {
        logic [PC_W-1:0]          next_pc;
        logic [STAT_W-1:0]        status;
        logic                     write_valid;
        logic signed [WORD_W-1:0] write_value;
        logic [TOP_W-1:0]         stack_top;
        logic [BASE_W-1:0]        frame_base_out;
    } result_t;

endpackage

@@ rtl/pl0vm_instr_if.sv @@
interface pl0vm_instr_if;
    logic                  valid;
    logic                  ready;
    pl0vm_pkg::instr_t     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/pl0vm_result_if.sv @@
interface pl0vm_result_if;
    logic                  valid;
    logic                  ready;
    pl0vm_pkg::result_t    payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/pl0vm_ram.sv @@
module pl0vm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/pl0_register_stack_vm_core.sv @@
// PL/0 register-stack machine core.
// Channels: instr (sink) takes one instruction request with operation, target_reg,
// level_or_reg, operand_m and read_value; result (source) returns one request per
// instruction with next_pc, status, write_valid, write_value, stack_top and
// frame_base_out.
// Each instruction runs through a sequencer around one stack RAM and one register
// RAM, both with a registered read. The sequencer checks the register indices,
// reads the target register and the two operand registers, then branches: LOD,
// STO and CAL follow the static links one at a time, arithmetic passes the ALU,
// MUL a product register, and DIV and MOD a restoring divider (one quotient bit
// per cycle); a bad register index goes straight to the result, and a stopped
// machine straight to the output register.
// One instruction is in flight at a time; the next is taken in the idle cycle
// after the result has been handed to the output register.
// Reset: pc 0, base STACK_DEPTH-1, top STACK_DEPTH. A clearing pass then zeroes
// the stack RAM and register RAM, one entry per cycle over every stack entry;
// no instruction is accepted during it.
// When the receiver stalls, the result is held in the output register; a new
// instruction is still accepted, but its result waits until the held one is taken.
// After a fault or HLT every instruction returns the stop status unchanged.
module pl0_register_stack_vm_core #(
    parameter int unsigned STACK_DEPTH = 128,
    parameter int unsigned REG_COUNT   = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    pl0vm_instr_if.sink   instr,
    pl0vm_result_if.source result
);

    localparam int unsigned SA_W = $clog2(STACK_DEPTH);
    localparam int unsigned RA_W = $clog2(REG_COUNT);
    localparam int unsigned SP_W = SA_W + 1;
    localparam int unsigned W    = pl0vm_pkg::WORD_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RDR, S_RDR2, S_RDM, S_RDM2, S_WALK, S_WALK2,
        S_ADDR, S_LDW, S_LDW2, S_RET1, S_RET2, S_RET3, S_CAL1, S_CAL2,
        S_ALU, S_MUL, S_DIV, S_DIVF, S_DONE, S_OUT
    } state_t;

    state_t state_reg;

    pl0vm_pkg::instr_t ins_reg;
    logic [pl0vm_pkg::PC_W-1:0] pc_reg;
    logic [SP_W-1:0] base_reg;
    logic [SP_W-1:0] sp_reg;
    logic halted_reg;
    logic [pl0vm_pkg::STAT_W-1:0] stop_reg;
    logic [SP_W-1:0] clr_reg;
    logic [W-1:0] x_reg, y_reg, r_reg;
    logic [3:0] lv_reg;
    logic signed [W+1:0] at_reg;
    logic [W-1:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0] cnt_reg;
    logic [63:0] prod_reg;
    logic [pl0vm_pkg::STAT_W-1:0] st_reg;
    logic wv_reg;
    logic [W-1:0] wval_reg;
    logic [pl0vm_pkg::PC_W-1:0] npc_reg;
    logic rwe_reg;
    pl0vm_pkg::result_t out_reg;
    logic out_valid_reg;

    logic sw;
    logic [SA_W-1:0] swa, sra;
    logic [W-1:0] swd, srd;
    logic rw;
    logic [RA_W-1:0] rwa, rra;
    logic [W-1:0] rwd, rrd;

    pl0vm_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(sw), .waddr(swa), .wdata(swd), .raddr(sra), .rdata(srd));
    pl0vm_ram #(.WIDTH(W), .DEPTH(REG_COUNT)) u_regs (
        .clk(clk), .we(rw), .waddr(rwa), .wdata(rwd), .raddr(rra), .rdata(rrd));

    logic [pl0vm_pkg::OP_W-1:0] op;
    logic is_arith, need_r, need_l, need_m, bad_reg;
    logic signed [W+1:0] eff_addr;
    logic signed [W+1:0] ns;
    logic [W:0] trial;
    logic [W-1:0] ax, ay;

    assign op       = ins_reg.operation;
    assign is_arith = op >= pl0vm_pkg::OP_ADD && op <= pl0vm_pkg::OP_GEQ;
    assign need_r   = op == pl0vm_pkg::OP_LIT || op == pl0vm_pkg::OP_LOD
                   || op == pl0vm_pkg::OP_STO || op == pl0vm_pkg::OP_JPC
                   || op == pl0vm_pkg::OP_WRT || op == pl0vm_pkg::OP_RED
                   || op == pl0vm_pkg::OP_NEG || is_arith;
    assign need_l   = is_arith;
    assign need_m   = op == pl0vm_pkg::OP_LOD || op == pl0vm_pkg::OP_STO || is_arith;
    assign bad_reg  = (need_r && 32'(ins_reg.target_reg) >= 32'(REG_COUNT))
                   || (need_l && 32'(ins_reg.level_or_reg) >= 32'(REG_COUNT))
                   || (need_m && ins_reg.operand_m >= 32'(REG_COUNT));
    assign eff_addr = at_reg - (W+2)'($signed(y_reg));
    assign ns       = (W+2)'(sp_reg) - (W+2)'(ins_reg.operand_m);
    assign ax       = x_reg[W-1] ? -x_reg : x_reg;
    assign ay       = y_reg[W-1] ? -y_reg : y_reg;
    assign trial    = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};

    assign instr.ready  = state_reg == S_IDLE;
    assign result.valid = out_valid_reg;
    assign result.payload = out_reg;

    always_comb
    begin
        sw  = 1'b0;
        swa = '0;
        swd = '0;
        sra = '0;
        rw  = 1'b0;
        rwa = ins_reg.target_reg[RA_W-1:0];
        rwd = r_reg;
        rra = ins_reg.target_reg[RA_W-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                sw  = 1'b1;
                swa = clr_reg[SA_W-1:0];
                rw  = clr_reg < SP_W'(REG_COUNT);
                rwa = clr_reg[RA_W-1:0];
                rwd = '0;
            end
            S_RDR2: rra = ins_reg.level_or_reg[RA_W-1:0];
            S_RDM: rra = ins_reg.operand_m[RA_W-1:0];
            S_WALK: sra = at_reg[SA_W-1:0];
            S_ADDR: sra = eff_addr[SA_W-1:0];
            S_LDW: sra = at_reg[SA_W-1:0];
            S_RET1: sra = base_reg[SA_W-1:0] - SA_W'(1);
            S_RET2: sra = base_reg[SA_W-1:0] - SA_W'(2);
            S_CAL1:
            begin
                sw  = 1'b1;
                swa = sp_reg[SA_W-1:0] - SA_W'(1);
                swd = W'(at_reg);
            end
            S_CAL2:
            begin
                sw  = 1'b1;
                swa = sp_reg[SA_W-1:0] - SA_W'(2);
                swd = W'(base_reg);
            end
            S_DONE:
            begin
                rw  = rwe_reg;
                sw  = ins_reg.operation == pl0vm_pkg::OP_STO
                   || ins_reg.operation == pl0vm_pkg::OP_CAL;
                swa = ins_reg.operation == pl0vm_pkg::OP_CAL
                    ? sp_reg[SA_W-1:0] - SA_W'(3) : at_reg[SA_W-1:0];
                swd = ins_reg.operation == pl0vm_pkg::OP_CAL
                    ? W'(pc_reg + pl0vm_pkg::PC_W'(1)) : r_reg;
                sw  = sw && st_reg == pl0vm_pkg::ST_RUN;
                rw  = rw && st_reg == pl0vm_pkg::ST_RUN;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= '0;
            base_reg      <= SP_W'(STACK_DEPTH - 1);
            sp_reg        <= SP_W'(STACK_DEPTH);
            halted_reg    <= 1'b0;
            stop_reg      <= pl0vm_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + SP_W'(1);
                    if (clr_reg == SP_W'(STACK_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (instr.valid)
                    begin
                        ins_reg   <= instr.payload;
                        st_reg    <= pl0vm_pkg::ST_RUN;
                        wv_reg    <= 1'b0;
                        wval_reg  <= '0;
                        rwe_reg   <= 1'b0;
                        npc_reg   <= pc_reg + pl0vm_pkg::PC_W'(1);
                        at_reg    <= (W+2)'(base_reg);
                        lv_reg    <= instr.payload.level_or_reg;
                        state_reg <= halted_reg ? S_OUT : S_RDR;
                    end
                end
                S_RDR:
                begin
                    if (bad_reg)
                    begin
                        st_reg    <= pl0vm_pkg::ST_BADREG;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_RDR2;
                    end
                end
                S_RDR2:
                begin
                    r_reg     <= rrd;
                    state_reg <= S_RDM;
                end
                S_RDM:
                begin
                    x_reg     <= rrd;
                    state_reg <= S_RDM2;
                end
                S_RDM2:
                begin
                    y_reg <= rrd;
                    unique case (op)
                        pl0vm_pkg::OP_LIT:
                        begin
                            r_reg <= ins_reg.operand_m; rwe_reg <= 1'b1; state_reg <= S_DONE;
                        end
                        pl0vm_pkg::OP_RED:
                        begin
                            r_reg <= ins_reg.read_value; rwe_reg <= 1'b1; state_reg <= S_DONE;
                        end
                        pl0vm_pkg::OP_NEG:
                        begin
                            r_reg <= -r_reg; rwe_reg <= 1'b1; state_reg <= S_DONE;
                        end
                        pl0vm_pkg::OP_WRT:
                        begin
                            wv_reg <= 1'b1; wval_reg <= r_reg; state_reg <= S_DONE;
                        end
                        pl0vm_pkg::OP_JMP:
                        begin
                            npc_reg <= ins_reg.operand_m[15:0]; state_reg <= S_DONE;
                        end
                        pl0vm_pkg::OP_JPC:
                        begin
                            if (r_reg == '0)
                            begin
                                npc_reg <= ins_reg.operand_m[15:0];
                            end
                            state_reg <= S_DONE;
                        end
                        pl0vm_pkg::OP_HLT:
                        begin
                            st_reg <= pl0vm_pkg::ST_HALT; state_reg <= S_DONE;
                        end
                        pl0vm_pkg::OP_INC:
                        begin
                            if (ns < 0)
                            begin
                                st_reg <= pl0vm_pkg::ST_OVF;
                            end
                            else if (ns > (W+2)'(STACK_DEPTH))
                            begin
                                st_reg <= pl0vm_pkg::ST_OOB;
                            end
                            else
                            begin
                                at_reg <= ns;
                            end
                            state_reg <= S_DONE;
                        end
                        pl0vm_pkg::OP_RET:
                        begin
                            if (base_reg < SP_W'(2) || base_reg >= SP_W'(STACK_DEPTH))
                            begin
                                st_reg <= pl0vm_pkg::ST_OOB; state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_RET1;
                            end
                        end
                        pl0vm_pkg::OP_CAL:
                        begin
                            if (sp_reg < SP_W'(3))
                            begin
                                st_reg <= pl0vm_pkg::ST_OVF; state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_WALK;
                            end
                        end
                        pl0vm_pkg::OP_LOD, pl0vm_pkg::OP_STO: state_reg <= S_WALK;
                        default:
                        begin
                            state_reg <= is_arith ? S_ALU : S_DONE;
                        end
                    endcase
                end
                S_WALK:
                begin
                    if (at_reg < 0 || at_reg >= (W+2)'(STACK_DEPTH))
                    begin
                        st_reg <= pl0vm_pkg::ST_OOB; state_reg <= S_DONE;
                    end
                    else if (lv_reg != '0)
                    begin
                        lv_reg <= lv_reg - 4'd1; state_reg <= S_WALK2;
                    end
                    else if (op == pl0vm_pkg::OP_CAL)
                    begin
                        state_reg <= S_CAL1;
                    end
                    else
                    begin
                        state_reg <= S_ADDR;
                    end
                end
                S_WALK2:
                begin
                    at_reg    <= (W+2)'($signed(srd));
                    state_reg <= S_WALK;
                end
                S_ADDR:
                begin
                    if (eff_addr < 0 || eff_addr >= (W+2)'(STACK_DEPTH))
                    begin
                        st_reg <= pl0vm_pkg::ST_OOB; state_reg <= S_DONE;
                    end
                    else
                    begin
                        at_reg    <= eff_addr;
                        state_reg <= op == pl0vm_pkg::OP_LOD ? S_LDW : S_DONE;
                    end
                end
                S_LDW: state_reg <= S_LDW2;
                S_LDW2:
                begin
                    r_reg <= srd; rwe_reg <= 1'b1; state_reg <= S_DONE;
                end
                S_RET1: state_reg <= S_RET2;
                S_RET2:
                begin
                    if ($signed(srd) < 0 || $signed(srd) >= $signed(W'(STACK_DEPTH)))
                    begin
                        st_reg <= pl0vm_pkg::ST_OOB; state_reg <= S_DONE;
                    end
                    else
                    begin
                        x_reg <= srd; state_reg <= S_RET3;
                    end
                end
                S_RET3:
                begin
                    npc_reg   <= srd[15:0];
                    state_reg <= S_DONE;
                end
                S_CAL1: state_reg <= S_CAL2;
                S_CAL2:
                begin
                    npc_reg <= ins_reg.operand_m[15:0]; state_reg <= S_DONE;
                end
                S_ALU:
                begin
                    rwe_reg <= 1'b1;
                    state_reg <= S_DONE;
                    unique case (op)
                        pl0vm_pkg::OP_ADD: r_reg <= x_reg + y_reg;
                        pl0vm_pkg::OP_SUB: r_reg <= x_reg - y_reg;
                        pl0vm_pkg::OP_MUL:
                        begin
                            prod_reg <= 64'(x_reg) * 64'(y_reg); state_reg <= S_MUL;
                        end
                        pl0vm_pkg::OP_DIV, pl0vm_pkg::OP_MOD:
                        begin
                            if (y_reg == '0)
                            begin
                                st_reg <= pl0vm_pkg::ST_DIV0;
                            end
                            else
                            begin
                                rem_reg <= '0; quo_reg <= ax; dvs_reg <= ay;
                                cnt_reg <= 6'd0; state_reg <= S_DIV;
                            end
                        end
                        pl0vm_pkg::OP_EQL: r_reg <= W'(x_reg == y_reg);
                        pl0vm_pkg::OP_NEQ: r_reg <= W'(x_reg != y_reg);
                        pl0vm_pkg::OP_LSS: r_reg <= W'($signed(x_reg) < $signed(y_reg));
                        pl0vm_pkg::OP_LEQ: r_reg <= W'($signed(x_reg) <= $signed(y_reg));
                        pl0vm_pkg::OP_GTR: r_reg <= W'($signed(x_reg) > $signed(y_reg));
                        default: r_reg <= W'($signed(x_reg) >= $signed(y_reg));
                    endcase
                end
                S_MUL:
                begin
                    r_reg <= prod_reg[W-1:0]; state_reg <= S_DONE;
                end
                S_DIV:
                begin
                    if (!trial[W])
                    begin
                        rem_reg <= trial[W-1:0];
                        quo_reg <= {quo_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                        quo_reg <= {quo_reg[W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(W - 1))
                    begin
                        state_reg <= S_DIVF;
                    end
                end
                S_DIVF:
                begin
                    if (op == pl0vm_pkg::OP_DIV)
                    begin
                        r_reg <= (x_reg[W-1] ^ y_reg[W-1]) ? -quo_reg : quo_reg;
                    end
                    else
                    begin
                        r_reg <= x_reg[W-1] ? -rem_reg : rem_reg;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    pc_reg <= npc_reg;
                    if (st_reg != pl0vm_pkg::ST_RUN)
                    begin
                        halted_reg <= 1'b1;
                        stop_reg   <= st_reg;
                    end
                    else if (op == pl0vm_pkg::OP_INC)
                    begin
                        sp_reg <= SP_W'(at_reg);
                    end
                    else if (op == pl0vm_pkg::OP_RET)
                    begin
                        sp_reg   <= base_reg + SP_W'(1);
                        base_reg <= SP_W'(x_reg);
                    end
                    else if (op == pl0vm_pkg::OP_CAL)
                    begin
                        base_reg <= sp_reg - SP_W'(1);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_reg.next_pc        <= pc_reg;
                        out_reg.status         <= halted_reg ? stop_reg : pl0vm_pkg::ST_RUN;
                        out_reg.write_valid    <= wv_reg && !halted_reg;
                        out_reg.write_value    <= halted_reg ? '0 : wval_reg;
                        out_reg.stack_top      <= pl0vm_pkg::TOP_W'(sp_reg);
                        out_reg.frame_base_out <= pl0vm_pkg::BASE_W'(base_reg);
                        out_valid_reg          <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    ap_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        instr.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    ap_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer out of range");
    ap_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared");
    ap_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !instr.ready)
        else $error("accept during clear");

endmodule

@@ tb/pl0vm_checker.sv @@
`timescale 1ns / 100ps

module pl0vm_checker #(
    parameter int unsigned STACK_DEPTH = 128,
    parameter int unsigned REG_COUNT   = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  pl0vm_pkg::instr_t   in_payload,
    input  logic                out_valid,
    input  logic                out_ready,
    input  pl0vm_pkg::result_t  out_payload,
    output int                  fail_count,
    output int                  pending,
    output int                  checked,
    output int                  writes_seen
);

    logic [pl0vm_pkg::PC_W-1:0]   pc_q;
    int unsigned                  fb_q;
    int unsigned                  sp_q;
    bit                           stopped_q;
    logic [pl0vm_pkg::STAT_W-1:0] stop_q;
    logic [pl0vm_pkg::WORD_W-1:0] regs_q [REG_COUNT];
    logic [pl0vm_pkg::WORD_W-1:0] stk_q  [STACK_DEPTH];

    pl0vm_pkg::result_t expected_results [$];

    function automatic bit addr_in_range(input longint a);
        return a >= 0 && a < longint'(STACK_DEPTH);
    endfunction

    // Execute one instruction on a copy of the machine; keep the copy when commit is set.
    function automatic pl0vm_pkg::result_t exec_instr(input pl0vm_pkg::instr_t it,
                                                      input bit commit);
        logic [pl0vm_pkg::PC_W-1:0]   pc;
        logic [pl0vm_pkg::PC_W-1:0]   npc;
        int unsigned                  fb;
        int unsigned                  sp;
        bit                           stp;
        logic [pl0vm_pkg::STAT_W-1:0] code;
        logic [pl0vm_pkg::WORD_W-1:0] rg [REG_COUNT];
        logic [pl0vm_pkg::WORD_W-1:0] st [STACK_DEPTH];
        logic [pl0vm_pkg::STAT_W-1:0] status;
        logic                         wv;
        logic [pl0vm_pkg::WORD_W-1:0] wval;
        logic [pl0vm_pkg::OP_W-1:0]   op;
        int unsigned                  r;
        int unsigned                  l;
        logic [pl0vm_pkg::WORD_W-1:0] m;
        bit                           need_r;
        bit                           need_l;
        bit                           need_m;
        bit                           is_arith;
        bit                           link_ok;
        longint                       at;
        longint                       a;
        longint                       nb;
        longint                       ns;
        longint                       sx;
        longint                       sy;
        logic [pl0vm_pkg::WORD_W-1:0] x;
        logic [pl0vm_pkg::WORD_W-1:0] y;
        logic [pl0vm_pkg::WORD_W-1:0] res;
        pl0vm_pkg::result_t           out;
        pc = pc_q; fb = fb_q; sp = sp_q; stp = stopped_q; code = stop_q;
        foreach (rg[k]) rg[k] = regs_q[k];
        foreach (st[k]) st[k] = stk_q[k];
        status = pl0vm_pkg::ST_RUN; wv = 1'b0; wval = '0;
        op = it.operation;
        r = 32'(it.target_reg);
        l = 32'(it.level_or_reg);
        m = it.operand_m;
        if (stp) begin
            status = code;
        end
        else begin
            npc = pc + 16'd1;
            is_arith = op >= pl0vm_pkg::OP_ADD && op <= pl0vm_pkg::OP_GEQ;
            need_r = op inside {pl0vm_pkg::OP_LIT, pl0vm_pkg::OP_LOD, pl0vm_pkg::OP_STO,
                                pl0vm_pkg::OP_JPC, pl0vm_pkg::OP_WRT, pl0vm_pkg::OP_RED,
                                pl0vm_pkg::OP_NEG} || is_arith;
            need_l = is_arith;
            need_m = op inside {pl0vm_pkg::OP_LOD, pl0vm_pkg::OP_STO} || is_arith;
            link_ok = 1'b1;
            at = longint'(fb);
            if (op inside {pl0vm_pkg::OP_LOD, pl0vm_pkg::OP_STO, pl0vm_pkg::OP_CAL}) begin
                for (int k = 0; k < l; k++) begin
                    if (link_ok && !addr_in_range(at))
                        link_ok = 1'b0;
                    if (link_ok)
                        at = longint'($signed(st[at]));
                end
                if (!addr_in_range(at))
                    link_ok = 1'b0;
            end
            if ((need_r && r >= REG_COUNT) || (need_l && l >= REG_COUNT)
                || (need_m && m >= REG_COUNT)) begin
                status = pl0vm_pkg::ST_BADREG;
            end
            else begin
                case (op)
                    pl0vm_pkg::OP_LIT: rg[r] = m;
                    pl0vm_pkg::OP_RET: begin
                        if (fb < 2 || !addr_in_range(longint'(fb)))
                            status = pl0vm_pkg::ST_OOB;
                        else begin
                            nb = longint'($signed(st[fb-1]));
                            if (!addr_in_range(nb)) status = pl0vm_pkg::ST_OOB;
                            else begin
                                npc = st[fb-2][pl0vm_pkg::PC_W-1:0];
                                sp = fb + 1;
                                fb = 32'(nb);
                            end
                        end
                    end
                    pl0vm_pkg::OP_LOD, pl0vm_pkg::OP_STO: begin
                        if (!link_ok) status = pl0vm_pkg::ST_OOB;
                        else begin
                            a = at - longint'($signed(rg[m]));
                            if (!addr_in_range(a)) status = pl0vm_pkg::ST_OOB;
                            else if (op == pl0vm_pkg::OP_LOD) rg[r] = st[a];
                            else st[a] = rg[r];
                        end
                    end
                    pl0vm_pkg::OP_CAL: begin
                        if (sp < 3) status = pl0vm_pkg::ST_OVF;
                        else if (sp > STACK_DEPTH || !link_ok) status = pl0vm_pkg::ST_OOB;
                        else begin
                            st[sp-1] = at[pl0vm_pkg::WORD_W-1:0];
                            st[sp-2] = fb;
                            st[sp-3] = 32'(npc);
                            fb = sp - 1;
                            npc = m[pl0vm_pkg::PC_W-1:0];
                        end
                    end
                    pl0vm_pkg::OP_INC: begin
                        ns = longint'(sp) - longint'($signed(m));
                        if (ns < 0) status = pl0vm_pkg::ST_OVF;
                        else if (ns > longint'(STACK_DEPTH)) status = pl0vm_pkg::ST_OOB;
                        else sp = 32'(ns);
                    end
                    pl0vm_pkg::OP_JMP: npc = m[pl0vm_pkg::PC_W-1:0];
                    pl0vm_pkg::OP_JPC: if (rg[r] == '0) npc = m[pl0vm_pkg::PC_W-1:0];
                    pl0vm_pkg::OP_WRT: begin
                        wv = 1'b1;
                        wval = rg[r];
                    end
                    pl0vm_pkg::OP_RED: rg[r] = it.read_value;
                    pl0vm_pkg::OP_HLT: status = pl0vm_pkg::ST_HALT;
                    pl0vm_pkg::OP_NEG: rg[r] = -rg[r];
                    default: begin
                        if (is_arith) begin
                            x = rg[l]; y = rg[m];
                            sx = longint'($signed(x)); sy = longint'($signed(y));
                            res = '0;
                            case (op)
                                pl0vm_pkg::OP_ADD: res = x + y;
                                pl0vm_pkg::OP_SUB: res = x - y;
                                pl0vm_pkg::OP_MUL: res = x * y;
                                pl0vm_pkg::OP_DIV: if (sy != 0) res = 32'(sx / sy);
                                pl0vm_pkg::OP_MOD: if (sy != 0) res = 32'(sx % sy);
                                pl0vm_pkg::OP_EQL: res = 32'(sx == sy);
                                pl0vm_pkg::OP_NEQ: res = 32'(sx != sy);
                                pl0vm_pkg::OP_LSS: res = 32'(sx < sy);
                                pl0vm_pkg::OP_LEQ: res = 32'(sx <= sy);
                                pl0vm_pkg::OP_GTR: res = 32'(sx > sy);
                                default: res = 32'(sx >= sy);
                            endcase
                            if ((op == pl0vm_pkg::OP_DIV || op == pl0vm_pkg::OP_MOD) && sy == 0)
                                status = pl0vm_pkg::ST_DIV0;
                            else rg[r] = res;
                        end
                    end
                endcase
            end
            pc = npc;
            if (status != pl0vm_pkg::ST_RUN) begin
                stp = 1'b1;
                code = status;
            end
        end
        out.next_pc        = pc;
        out.status         = status;
        out.write_valid    = wv;
        out.write_value    = wval;
        out.stack_top      = sp[pl0vm_pkg::TOP_W-1:0];
        out.frame_base_out = fb[pl0vm_pkg::BASE_W-1:0];
        if (commit) begin
            pc_q = pc; fb_q = fb; sp_q = sp; stopped_q = stp; stop_q = code;
            foreach (rg[k]) regs_q[k] = rg[k];
            foreach (st[k]) stk_q[k] = st[k];
        end
        return out;
    endfunction

    task automatic compare_field(input string name,
                                 input logic [pl0vm_pkg::WORD_W-1:0] exp_v,
                                 input logic [pl0vm_pkg::WORD_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        pl0vm_pkg::result_t exp_r;
        if (!rst_n) begin
            pc_q        = '0;
            fb_q        = STACK_DEPTH - 1;
            sp_q        = STACK_DEPTH;
            stopped_q   = 1'b0;
            stop_q      = pl0vm_pkg::ST_RUN;
            fail_count  = 0;
            pending     = 0;
            checked     = 0;
            writes_seen = 0;
            foreach (regs_q[k]) regs_q[k] = '0;
            foreach (stk_q[k]) stk_q[k] = '0;
            expected_results.delete();
        end
        else begin
            if (in_valid && in_ready)
                expected_results.push_back(exec_instr(in_payload, 1'b1));
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, out_payload);
                    fail_count++;
                end
                else begin
                    exp_r = expected_results.pop_front();
                    compare_field("next_pc", 32'(exp_r.next_pc), 32'(out_payload.next_pc));
                    compare_field("status", 32'(exp_r.status), 32'(out_payload.status));
                    compare_field("write_valid", 32'(exp_r.write_valid),
                                  32'(out_payload.write_valid));
                    compare_field("write_value", exp_r.write_value, out_payload.write_value);
                    compare_field("stack_top", 32'(exp_r.stack_top),
                                  32'(out_payload.stack_top));
                    compare_field("frame_base_out", 32'(exp_r.frame_base_out),
                                  32'(out_payload.frame_base_out));
                    checked++;
                    if (exp_r.write_valid) writes_seen++;
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

@@ tb/tb_pl0_register_stack_vm_core.sv @@
`timescale 1ns / 100ps

module tb_pl0_register_stack_vm_core;

    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 2000000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   writes_seen;
    int   cycles = 0;
    bit   stim_done;

    pl0vm_instr_if  instr_ch ();
    pl0vm_result_if result_ch ();

    pl0_register_stack_vm_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    pl0vm_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (instr_ch.valid),
        .in_ready    (instr_ch.ready),
        .in_payload  (instr_ch.payload),
        .out_valid   (result_ch.valid),
        .out_ready   (result_ch.ready),
        .out_payload (result_ch.payload),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .writes_seen (writes_seen)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** pl0_register_stack_vm_core: FAILED **");
            $finish;
        end
    end

    function automatic pl0vm_pkg::instr_t make_instr(input logic [pl0vm_pkg::OP_W-1:0] op,
                                                     input int r, input int l,
                                                     input logic [pl0vm_pkg::WORD_W-1:0] m,
                                                     input logic [pl0vm_pkg::WORD_W-1:0] rd);
        pl0vm_pkg::instr_t it;
        it.operation    = op;
        it.target_reg   = 4'(r);
        it.level_or_reg = 4'(l);
        it.operand_m    = m;
        it.read_value   = rd;
        return it;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request and hold it until the handshake.
    task automatic issue(input pl0vm_pkg::instr_t it);
        @(posedge clk);
        instr_ch.valid   <= 1'b1;
        instr_ch.payload <= it;
        forever begin
            @(negedge clk);
            if (instr_ch.ready) break;
        end
        @(posedge clk);
        instr_ch.valid <= 1'b0;
        @(negedge clk);
        repeat (pick_gap()) @(posedge clk);
    endtask

    function automatic pl0vm_pkg::instr_t random_instr();
        int p;
        logic [pl0vm_pkg::WORD_W-1:0] m;
        p = $urandom_range(0, 99);
        m = ($urandom_range(0, 1)) ? $urandom : 32'($signed($urandom_range(0, 16)) - 8);
        if (p < 20)
            return make_instr(pl0vm_pkg::OP_LIT, $urandom_range(0, 9), $urandom_range(0, 15),
                              m, $urandom);
        if (p < 45)
            return make_instr(5'($urandom_range(pl0vm_pkg::OP_ADD, pl0vm_pkg::OP_GEQ)),
                              $urandom_range(0, 9), $urandom_range(0, 9),
                              $urandom_range(0, 9), $urandom);
        if (p < 57)
            return make_instr($urandom_range(0, 1) ? pl0vm_pkg::OP_LOD : pl0vm_pkg::OP_STO,
                              $urandom_range(0, 9), $urandom_range(0, 2),
                              $urandom_range(0, 9), $urandom);
        if (p < 63)
            return make_instr(pl0vm_pkg::OP_CAL, $urandom_range(0, 15), $urandom_range(0, 2),
                              $urandom, $urandom);
        if (p < 69)
            return make_instr(pl0vm_pkg::OP_RET, $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom, $urandom);
        if (p < 75)
            return make_instr(pl0vm_pkg::OP_INC, $urandom_range(0, 15), $urandom_range(0, 15),
                              32'($signed($urandom_range(0, 10)) - 5), $urandom);
        if (p < 80)
            return make_instr($urandom_range(0, 1) ? pl0vm_pkg::OP_JMP : pl0vm_pkg::OP_JPC,
                              $urandom_range(0, 9), $urandom_range(0, 15), $urandom, $urandom);
        if (p < 86)
            return make_instr(pl0vm_pkg::OP_WRT, $urandom_range(0, 9), $urandom_range(0, 15),
                              $urandom, $urandom);
        if (p < 91)
            return make_instr(pl0vm_pkg::OP_RED, $urandom_range(0, 9), $urandom_range(0, 15),
                              $urandom, $urandom);
        if (p < 95)
            return make_instr(pl0vm_pkg::OP_NEG, $urandom_range(0, 9), $urandom_range(0, 15),
                              $urandom, $urandom);
        return make_instr($urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(24, 31)),
                          $urandom_range(0, 15), $urandom_range(0, 15), $urandom, $urandom);
    endfunction

    initial begin
        pl0vm_pkg::instr_t  cand;
        pl0vm_pkg::result_t probe;
        bit                 ok;
        instr_ch.valid   <= 1'b0;
        instr_ch.payload <= '0;
        stim_done = 1'b0;
        rst_n     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        issue(make_instr(pl0vm_pkg::OP_LIT, 0, 15, 32'h7fffffff, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_LIT, 1, 0, 32'h80000000, 32'hffffffff));
        issue(make_instr(pl0vm_pkg::OP_LIT, 2, 0, 32'hffffffff, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_LIT, 3, 0, 32'd1, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_ADD, 4, 0, 32'd3, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_SUB, 5, 1, 32'd3, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_MUL, 6, 0, 32'd0, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_DIV, 7, 1, 32'd2, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_MOD, 8, 1, 32'd2, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_NEG, 9, 0, 32'h0, 32'h0));
        for (int op = pl0vm_pkg::OP_EQL; op <= pl0vm_pkg::OP_GEQ; op++)
            issue(make_instr(5'(op), 4, 1, 32'd0, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_WRT, 1, 0, 32'h0, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_RED, 5, 0, 32'h0, 32'h80000000));
        issue(make_instr(pl0vm_pkg::OP_JPC, 9, 0, 32'h1234, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_JMP, 15, 15, 32'hffffffff, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_CAL, 0, 0, 32'd100, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_INC, 0, 0, 32'd5, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_LIT, 3, 0, 32'd4, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_STO, 0, 0, 32'd3, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_LOD, 6, 0, 32'd3, 32'h0));
        issue(make_instr(pl0vm_pkg::OP_RET, 0, 0, 32'h0, 32'h0));
        issue(make_instr(5'd0, 15, 15, 32'hffffffff, 32'hffffffff));
        issue(make_instr(5'd31, 0, 0, 32'h0, 32'h0));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            ok = 1'b0;
            for (int t = 0; t < 40 && !ok; t++) begin
                cand = random_instr();
                probe = u_chk.exec_instr(cand, 1'b0);
                ok = probe.status == pl0vm_pkg::ST_RUN;
            end
            if (!ok) cand = make_instr(pl0vm_pkg::OP_WRT, 0, 0, 32'h0, 32'h0);
            issue(cand);
        end

        case ($urandom_range(0, 4))
            0: issue(make_instr(pl0vm_pkg::OP_HLT, 0, 0, 32'h0, 32'h0));
            1: issue(make_instr(pl0vm_pkg::OP_LIT, 12, 0, 32'h0, 32'h0));
            2: issue(make_instr(pl0vm_pkg::OP_INC, 0, 0, 32'd1000, 32'h0));
            3: issue(make_instr(pl0vm_pkg::OP_INC, 0, 0, 32'hfffffc18, 32'h0));
            default: begin
                issue(make_instr(pl0vm_pkg::OP_LIT, 0, 0, 32'h0, 32'h0));
                issue(make_instr(pl0vm_pkg::OP_DIV, 1, 1, 32'd0, 32'h0));
            end
        endcase
        for (int n = 0; n < 20; n++)
            issue(make_instr(5'($urandom_range(0, 31)), $urandom_range(0, 15),
                             $urandom_range(0, 15), $urandom, $urandom));
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold while requests keep coming.
    initial begin
        int p;
        bit held;
        result_ch.ready <= 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!held && cycles > 3000) begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            p = $urandom_range(0, 99);
            if (p < 70) begin
                result_ch.ready <= 1'b1;
            end
            else begin
                result_ch.ready <= 1'b0;
                repeat ((p < 97) ? $urandom_range(0, 3) : $urandom_range(20, 40))
                    @(posedge clk);
            end
        end
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Checked %0d results, %0d of them with output writes,", checked, writes_seen);
        $display("over arithmetic, call/return, stack access, a long stall and a final stop.");
        if (fail_count == 0)
            $display("** pl0_register_stack_vm_core: PASSED **");
        else
            $display("** pl0_register_stack_vm_core: FAILED **");
        $finish;
    end

endmodule
